>>> hw/rtl/char_lcd_nibble_command_writer_assert.svh
// Assertion macros used by the LCD nibble writer top level.
`ifndef CHAR_LCD_NIBBLE_COMMAND_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_COMMAND_WRITER_ASSERT_SVH

// Condition holds on every clock out of reset.
`define LCDW_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LCDW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LCDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lcdw_pkg.sv
// Types, constants and helper functions for the LCD nibble writer.
`default_nettype none

package lcdw_pkg;

    localparam int ACTION_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 5;
    localparam int GLYPH_W     = 3;
    localparam int PIN_W       = 5;
    localparam int NIB_W       = 4;
    localparam int WAIT_W      = 13;
    localparam int CURSOR_W    = 6;
    localparam int DDADDR_W    = 7;
    localparam int STEP_W      = 4;

    localparam int LINE_LENGTH = 16;

    localparam logic [CURSOR_W-1:0] LINE_LEN_C = CURSOR_W'(LINE_LENGTH);
    localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;
    localparam logic [DDADDR_W-1:0] LINE2_BASE = 7'h40;

    localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'h20;
    localparam logic [CHAR_W-1:0] CMD_CLEAR     = 8'h01;
    localparam logic [1:0]        CGRAM_PREFIX  = 2'b01;
    localparam logic              DDRAM_PREFIX  = 1'b1;

    localparam logic [WAIT_W-1:0] WAIT_NONE  = 13'd0;
    localparam logic [WAIT_W-1:0] WAIT_SHORT = 13'd50;
    localparam logic [WAIT_W-1:0] WAIT_LONG  = 13'd2000;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
    localparam logic [STEP_W-1:0] STEP_CMD_HI    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CMD_LO    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DATA_HI   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DATA_LO   = 4'd3;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_CHAR  = 2'd2,
        ACT_GLYPH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_CMD,
        JOB_CMD_DATA
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic              has_cmd;
        logic [CHAR_W-1:0] cmd;
        logic [CHAR_W-1:0] data;
    } job_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
    } fifo_status_t;

    function automatic logic [NIB_W-1:0] init_nibble(input logic [STEP_W-1:0] idx);
        logic [NIB_W-1:0] n;
        case (idx)
            4'd0, 4'd1, 4'd2: n = 4'h3;
            4'd3, 4'd4:       n = 4'h2;
            4'd5:             n = 4'h8;
            4'd7:             n = 4'hC;
            4'd9:             n = 4'h1;
            4'd11:            n = 4'h6;
            default:          n = 4'h0;
        endcase
        return n;
    endfunction

    function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] idx);
        logic [WAIT_W-1:0] w;
        case (idx)
            4'd0:                   w = 13'd5000;
            4'd1, 4'd2, 4'd3, 4'd5: w = 13'd1000;
            4'd7:                   w = WAIT_SHORT;
            4'd9, 4'd11:            w = WAIT_LONG;
            default:                w = WAIT_NONE;
        endcase
        return w;
    endfunction

    // DDRAM address of a cursor position: line two starts at 0x40.
    function automatic logic [DDADDR_W-1:0] ddram_addr(input logic [CURSOR_W-1:0] pos);
        logic [DDADDR_W-1:0] a;
        if (pos < LINE_LEN_C)
            a = DDADDR_W'(pos);
        else
            a = LINE2_BASE + DDADDR_W'(pos - LINE_LEN_C);
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcdw_if.sv
// Valid/ready channel interfaces for command beats and pin-word beats.
`default_nettype none

interface lcdw_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lcdw_pkg::ACTION_W-1:0] action;
    logic [lcdw_pkg::CHAR_W-1:0]   char_code;
    logic [lcdw_pkg::POS_W-1:0]    start_pos;
    logic                          first_char;
    logic [lcdw_pkg::GLYPH_W-1:0]  glyph_index;
    logic [lcdw_pkg::GLYPH_W-1:0]  glyph_row;
    logic [lcdw_pkg::CHAR_W-1:0]   row_dots;

    modport source (
        output valid, action, char_code, start_pos, first_char,
               glyph_index, glyph_row, row_dots,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, start_pos, first_char,
               glyph_index, glyph_row, row_dots,
        output ready
    );
endinterface

interface lcdw_nib_if;
    logic                        valid;
    logic                        ready;
    logic [lcdw_pkg::PIN_W-1:0]  pin_word;
    logic [lcdw_pkg::WAIT_W-1:0] wait_after_us;
    logic                        last_of_run;

    modport source (output valid, pin_word, wait_after_us, last_of_run, input ready);
    modport sink   (input  valid, pin_word, wait_after_us, last_of_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lcdw_front.sv
// Front end: takes command beats, tracks the cursor and builds nibble jobs.
`default_nettype none

module lcdw_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lcdw_cmd_if.sink            cmd,
    output lcdw_pkg::job_t      push_job,
    output logic                push_valid,
    input  wire logic           push_ready
);
    import lcdw_pkg::*;

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic                line1_reg, line1_next;
    logic                ended_reg, ended_next;

    logic [CURSOR_W-1:0] start_ext;
    logic [CURSOR_W-1:0] base_cursor;
    logic                base_ended;
    logic                is_nul;
    logic                accept;
    job_t                job;

    assign start_ext   = CURSOR_W'(cmd.start_pos);
    assign base_cursor = cmd.first_char ? start_ext : cursor_reg;
    assign base_ended  = cmd.first_char ? 1'b0 : ended_reg;
    assign is_nul      = (cmd.char_code == '0) || base_ended;
    assign accept      = cmd.valid && push_ready;

    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid;
    assign push_job   = job;

    always_comb
    begin
        job.kind    = JOB_CMD_DATA;
        job.has_cmd = 1'b1;
        job.cmd     = '0;
        job.data    = '0;
        case (action_t'(cmd.action))
            ACT_INIT:
            begin
                job.kind = JOB_INIT;
            end
            ACT_CLEAR:
            begin
                job.kind = JOB_CMD;
                job.cmd  = CMD_CLEAR;
            end
            ACT_CHAR:
            begin
                if (cmd.first_char)
                    job.cmd = {DDRAM_PREFIX, ddram_addr(start_ext)};
                else
                    job.cmd = {DDRAM_PREFIX, LINE2_BASE};
                // Re-address only on a string start or the wrap to line two.
                job.has_cmd = cmd.first_char || (line1_reg && (cursor_reg == LINE_LEN_C));
                job.data    = is_nul ? SPACE_CHAR : cmd.char_code;
            end
            ACT_GLYPH:
            begin
                job.cmd  = {CGRAM_PREFIX, cmd.glyph_index, cmd.glyph_row};
                job.data = cmd.row_dots;
            end
            default:
            begin
                job.kind = JOB_INIT;
            end
        endcase
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        line1_next  = line1_reg;
        ended_next  = ended_reg;
        if (accept && (action_t'(cmd.action) == ACT_CHAR))
        begin
            if (cmd.first_char)
                line1_next = (start_ext < LINE_LEN_C);
            ended_next  = is_nul;
            cursor_next = (base_cursor == CURSOR_MAX) ? base_cursor
                                                      : base_cursor + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            line1_reg  <= 1'b0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            line1_reg  <= line1_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcdw_job_fifo.sv
// Short job queue between the front end and the nibble sequencer.
`default_nettype none

module lcdw_job_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    input  wire lcdw_pkg::job_t      push_job,
    output logic                     push_ready,
    output logic                     pop_valid,
    output lcdw_pkg::job_t           pop_job,
    input  wire logic                pop,
    output lcdw_pkg::fifo_status_t   status
);
    import lcdw_pkg::*;

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready   = (count_reg != CNT_FULL);
    assign pop_valid    = (count_reg != '0);
    assign pop_job      = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcdw_back.sv
// Back end: walks the head job, one pin-word beat per cycle while ready.
`default_nettype none

module lcdw_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    input  wire lcdw_pkg::job_t job,
    output logic                job_pop,
    lcdw_nib_if.source          nib
);
    import lcdw_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]  pin_reg, pin_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              last_reg, last_next;

    logic [STEP_W-1:0] idx;
    logic [PIN_W-1:0]  gen_pin;
    logic [WAIT_W-1:0] gen_wait;
    logic              gen_last;
    logic              load;

    // A character job without re-addressing starts at the data nibbles.
    assign idx = ((job.kind == JOB_CMD_DATA) && !job.has_cmd) ? step_reg + STEP_DATA_HI
                                                               : step_reg;

    always_comb
    begin
        gen_pin  = '0;
        gen_wait = WAIT_NONE;
        gen_last = 1'b0;
        case (job.kind)
            JOB_INIT:
            begin
                gen_pin  = {1'b0, init_nibble(idx)};
                gen_wait = init_wait(idx);
                gen_last = (idx == INIT_LAST_STEP);
            end
            JOB_CMD:
            begin
                if (idx == STEP_CMD_HI)
                    gen_pin = {1'b0, job.cmd[7:4]};
                else
                begin
                    gen_pin  = {1'b0, job.cmd[3:0]};
                    gen_wait = WAIT_LONG;
                    gen_last = 1'b1;
                end
            end
            JOB_CMD_DATA:
            begin
                case (idx)
                    STEP_CMD_HI: gen_pin = {1'b0, job.cmd[7:4]};
                    STEP_CMD_LO:
                    begin
                        gen_pin  = {1'b0, job.cmd[3:0]};
                        gen_wait = WAIT_SHORT;
                    end
                    STEP_DATA_HI: gen_pin = {1'b1, job.data[7:4]};
                    default:
                    begin
                        gen_pin  = {1'b1, job.data[3:0]};
                        gen_wait = WAIT_SHORT;
                        gen_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                gen_last = 1'b1;
            end
        endcase
    end

    assign load    = job_valid && (!out_valid_reg || nib.ready);
    assign job_pop = load && gen_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !nib.ready;
        pin_next       = pin_reg;
        wait_next      = wait_reg;
        last_next      = last_reg;
        if (load)
        begin
            step_next      = gen_last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
            pin_next       = gen_pin;
            wait_next      = gen_wait;
            last_next      = gen_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pin_reg  <= pin_next;
        wait_reg <= wait_next;
        last_reg <= last_next;
    end

    assign nib.valid         = out_valid_reg;
    assign nib.pin_word      = pin_reg;
    assign nib.wait_after_us = wait_reg;
    assign nib.last_of_run   = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/char_lcd_nibble_command_writer.sv
// Top level: 4-bit character LCD command writer, front end, job queue, sequencer.
`default_nettype none

// Turns display commands into 5-bit pin words (bit 4 register select, bits 3-0
// D7..D4), each with the wait in microseconds to hold after strobing it, and
// flags the final nibble of each command. Actions: init (12 nibbles), clear
// (2), write character (2, or 4 when the cursor address goes out first: on
// the first character of a string and on the wrap from line one to line two),
// glyph row (4). After a NUL the rest of the string is padded with spaces
// until the next first character. Throughput is one pin-word beat per clock,
// set by the back-end sequencer, while a job is queued and the pin-word sink
// is ready. The front end classifies a command in the cycle it is accepted
// and parks it in a two-entry job queue; it keeps taking commands while the
// queue has room, even while the sequencer is stalled by the pin-word sink.
// After acceptance, the first nibble of a command passes through the job
// queue and then the registered pin-word output, which is held while ready
// is low. Enable-pulse timing and the power-on delay are the consumer's job.

`include "char_lcd_nibble_command_writer_assert.svh"

module char_lcd_nibble_command_writer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lcdw_cmd_if.sink   cmd,
    lcdw_nib_if.source nib
);
    import lcdw_pkg::*;

    // Front end to queue.
    job_t         push_job;
    logic         push_valid;
    logic         push_ready;

    // Queue to sequencer.
    logic         head_valid;
    job_t         head_job;
    logic         head_pop;
    fifo_status_t fifo_status;

    lcdw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    lcdw_job_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (head_valid),
        .pop_job    (head_job),
        .pop        (head_pop),
        .status     (fifo_status)
    );

    lcdw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (head_pop),
        .nib       (nib)
    );

    // Queue occupancy never passes its depth.
    `LCDW_ASSERT_ALWAYS(a_fifo_bound, fifo_status.count <= FIFO_CNT_W'(FIFO_DEPTH), "job queue overflow")

    // Commands are refused exactly when the queue is full.
    `LCDW_ASSERT_ALWAYS(a_ready_tracks_room, cmd.ready == (fifo_status.count != FIFO_CNT_W'(FIFO_DEPTH)), "ready disagrees with queue room")

    // With no job queued and nothing held, no beat can appear next cycle.
    `LCDW_ASSERT_NEXT(a_no_beat_from_nothing, (fifo_status.count == '0) && !nib.valid, !nib.valid, "pin word without a job")

endmodule

`default_nettype wire
